>>> rtl/ir_point_motion_inactivity_monitor_assert.svh
// Assertion macros shared by the monitor RTL.
`ifndef IR_POINT_MOTION_INACTIVITY_MONITOR_ASSERT_SVH
`define IR_POINT_MOTION_INACTIVITY_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipm assertion failed");

`endif

>>> rtl/ipm_pkg.sv
package ipm_pkg;

    // Geometry of the request fields.
    localparam int FIELD_SOURCES = 4;
    localparam int FIELD_COORD   = 10;
    localparam int THR_W         = 11;
    localparam int THR_SQ_W      = 22;
    localparam int WLEN_W        = 8;
    localparam int TICK_W        = 16;
    localparam int CNT_W         = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [TICK_W-1:0] IDLE_MAX = '1;

    // Register reset values.
    localparam logic [THR_W-1:0]  SHORT_THR_RST = 11'd5;
    localparam logic [THR_W-1:0]  LONG_THR_RST  = 11'd30;
    localparam logic [WLEN_W-1:0] WLEN_RST      = 8'd20;
    localparam logic [TICK_W-1:0] WARN_RST      = 16'd600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_THR = 2'd0,
        REG_LONG_THR  = 2'd1,
        REG_WLEN      = 2'd2,
        REG_WARN      = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        FUNC_REPORT = 1'b0,
        FUNC_TICK   = 1'b1
    } t_func;

    typedef struct packed {
        logic                   func;
        logic [3:0]             valid_mask;
        logic [FIELD_COORD-1:0] src0_x;
        logic [FIELD_COORD-1:0] src0_y;
        logic [FIELD_COORD-1:0] src1_x;
        logic [FIELD_COORD-1:0] src1_y;
        logic [FIELD_COORD-1:0] src2_x;
        logic [FIELD_COORD-1:0] src2_y;
        logic [FIELD_COORD-1:0] src3_x;
        logic [FIELD_COORD-1:0] src3_y;
    } t_in_item;

    typedef struct packed {
        logic             moving;
        logic             warned;
        logic             warn_start;
        logic [CNT_W-1:0] source_count;
    } t_out_item;

    // Status handed from the merge stage to the controller.
    typedef struct packed {
        logic             have;
        logic [CNT_W-1:0] count;
    } t_pick_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDIST,
        S_RPICK,
        S_RUPD,
        S_TDIST,
        S_TACC,
        S_WCHK,
        S_DIV,
        S_ADIST,
        S_AUPD,
        S_FIN
    } t_state;

endpackage

>>> rtl/ipm_lane.sv
module ipm_lane
    import ipm_pkg::*;
#(
    parameter int CW = 10
) (
    input  logic              i_clk,
    input  logic [CW-1:0]     i_tx,
    input  logic [CW-1:0]     i_ty,
    input  logic [CW-1:0]     i_sx,
    input  logic [CW-1:0]     i_sy,
    input  logic              i_valid,
    output logic [2*CW:0]     o_dist,
    output logic [CW-1:0]     o_x,
    output logic [CW-1:0]     o_y,
    output logic              o_valid
);

    logic [CW-1:0]   dx;
    logic [CW-1:0]   dy;
    logic [2*CW-1:0] sqx;
    logic [2*CW-1:0] sqy;
    logic [2*CW:0]   r_dist;
    logic [CW-1:0]   r_x;
    logic [CW-1:0]   r_y;
    logic            r_valid;

    // Squared distance from the tracked point to this source.
    assign dx  = (i_tx > i_sx) ? (i_tx - i_sx) : (i_sx - i_tx);
    assign dy  = (i_ty > i_sy) ? (i_ty - i_sy) : (i_sy - i_ty);
    assign sqx = (2*CW)'(dx) * (2*CW)'(dx);
    assign sqy = (2*CW)'(dy) * (2*CW)'(dy);

    // Lane result register.
    always_ff @(posedge i_clk) begin
        r_dist  <= {1'b0, sqx} + {1'b0, sqy};
        r_x     <= i_sx;
        r_y     <= i_sy;
        r_valid <= i_valid;
    end

    assign o_dist  = r_dist;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_valid = r_valid;

endmodule

>>> rtl/ipm_merge.sv
module ipm_merge
    import ipm_pkg::*;
#(
    parameter int NL = 4,
    parameter int CW = 10
) (
    input  logic                       i_clk,
    input  logic [NL-1:0][2*CW:0]      i_dist,
    input  logic [NL-1:0][CW-1:0]      i_x,
    input  logic [NL-1:0][CW-1:0]      i_y,
    input  logic [NL-1:0]              i_valid,
    output logic [CW-1:0]              o_x,
    output logic [CW-1:0]              o_y,
    output t_pick_stat                 o_stat
);

    logic [2*CW:0] best_d;
    logic [CW-1:0] best_x;
    logic [CW-1:0] best_y;
    logic          have;
    logic [CNT_W-1:0] count;
    logic [CW-1:0] r_x;
    logic [CW-1:0] r_y;
    t_pick_stat    r_stat;

    // Nearest valid source; a strict compare keeps the lowest lane on a tie.
    always_comb begin
        best_d = '0;
        best_x = '0;
        best_y = '0;
        have   = 1'b0;
        count  = '0;
        for (int n = 0; n < NL; n++) begin
            if (i_valid[n]) begin
                count = count + 1'b1;
                if (!have || (i_dist[n] < best_d)) begin
                    have   = 1'b1;
                    best_d = i_dist[n];
                    best_x = i_x[n];
                    best_y = i_y[n];
                end
            end
        end
    end

    // Merge result register.
    always_ff @(posedge i_clk) begin
        r_x          <= best_x;
        r_y          <= best_y;
        r_stat.have  <= have;
        r_stat.count <= count;
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_stat = r_stat;

endmodule

>>> rtl/ipm_div.sv
module ipm_div
    import ipm_pkg::*;
#(
    parameter int NUM_W = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [WLEN_W-1:0] i_den,
    output logic              o_busy,
    output logic [NUM_W-1:0]  o_quo
);

    localparam int CNT_BITS = $clog2(NUM_W + 1);

    logic [CNT_BITS-1:0] r_cnt;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    r_quo;
    logic [WLEN_W:0]     r_rem;
    logic [WLEN_W-1:0]   r_den;
    logic [WLEN_W:0]     rem_sh;
    logic                fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign rem_sh = {r_rem[WLEN_W-1:0], r_num[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    // Iteration counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_BITS'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Partial remainder and quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

>>> rtl/ir_point_motion_inactivity_monitor.sv
// IR point motion and inactivity monitor. For an IR report (func 0), one lane
// per light source computes the squared distance to the tracked point, a merge
// stage picks the nearest valid source and counts the valid ones, and the
// controller updates the tracked point. A sample tick (func 1) that closes an
// averaging window runs the bit-serial dividers, which form the window average
// one quotient bit per cycle. The input stays stalled until a request is done.
// One result request follows each tick and none follows a report. A finished
// result waits in an output register while the next request is taken; a tick
// holds in its last cycle while the previous result is still stalled.
// Inactivity is counted in ticks.
module ir_point_motion_inactivity_monitor
    import ipm_pkg::*;
#(
    parameter int SOURCES    = 4,
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

`include "ir_point_motion_inactivity_monitor_assert.svh"

    localparam int NL   = (SOURCES < FIELD_SOURCES) ? SOURCES : FIELD_SOURCES;
    localparam int CW   = (COORD_BITS < FIELD_COORD) ? COORD_BITS : FIELD_COORD;
    localparam int DW   = 2 * CW + 1;
    localparam int SW   = CW + WLEN_W;
    localparam int CMPW = (DW > THR_SQ_W) ? DW : THR_SQ_W;

    // Configuration registers and squared thresholds.
    logic [THR_W-1:0]    r_short;
    logic [THR_W-1:0]    r_long;
    logic [WLEN_W-1:0]   r_wlen;
    logic [TICK_W-1:0]   r_warn_ticks;
    logic [THR_SQ_W-1:0] r_st_sq;
    logic [THR_SQ_W-1:0] r_lt_sq;

    // Controller and tracking state.
    t_state            r_state;
    t_state            n_state;
    t_in_item          r_item;
    logic [CW-1:0]     r_tx;
    logic [CW-1:0]     r_ty;
    logic              r_fresh;
    logic [CNT_W-1:0]  r_latched;
    logic [CW-1:0]     r_px;
    logic [CW-1:0]     r_py;
    logic              r_long_mv;
    logic [SW-1:0]     r_sum_x;
    logic [SW-1:0]     r_sum_y;
    logic [WLEN_W-1:0] r_wc;
    logic [CW-1:0]     r_pax;
    logic [CW-1:0]     r_pay;
    logic [TICK_W-1:0] r_idle;
    logic              r_warn;
    logic              r_is_moving;
    logic [DW-1:0]     r_dist;
    logic              r_out_valid;
    t_out_item         r_out;

    // Lane and merge signals.
    logic [FIELD_SOURCES-1:0][FIELD_COORD-1:0] src_x;
    logic [FIELD_SOURCES-1:0][FIELD_COORD-1:0] src_y;
    logic [NL-1:0][DW-1:0] lane_dist;
    logic [NL-1:0][CW-1:0] lane_x;
    logic [NL-1:0][CW-1:0] lane_y;
    logic [NL-1:0]         lane_valid;
    logic [CW-1:0]         pick_x;
    logic [CW-1:0]         pick_y;
    t_pick_stat            pick_stat;

    // Divider and shared distance signals.
    logic              div_start;
    logic              div_busy_x;
    logic              div_busy_y;
    logic [SW-1:0]     quo_x;
    logic [SW-1:0]     quo_y;
    logic [WLEN_W-1:0] wlen_eff;
    logic [CW-1:0]     da_x;
    logic [CW-1:0]     da_y;
    logic [CW-1:0]     db_x;
    logic [CW-1:0]     db_y;
    logic [CW-1:0]     dx;
    logic [CW-1:0]     dy;
    logic [2*CW-1:0]   sqx;
    logic [2*CW-1:0]   sqy;
    logic              d_gt_st;
    logic              d_gt_lt;

    // Finishing step of a tick.
    logic              out_free;
    logic              out_write;
    logic              both;
    logic [TICK_W-1:0] idle_next;
    logic              warn_kept;
    logic              warn_rise;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short      <= SHORT_THR_RST;
            r_long       <= LONG_THR_RST;
            r_wlen       <= WLEN_RST;
            r_warn_ticks <= WARN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SHORT_THR: r_short      <= i_cfg_wdata[THR_W-1:0];
                REG_LONG_THR:  r_long       <= i_cfg_wdata[THR_W-1:0];
                REG_WLEN:      r_wlen       <= i_cfg_wdata[WLEN_W-1:0];
                REG_WARN:      r_warn_ticks <= i_cfg_wdata[TICK_W-1:0];
                default:       r_short      <= r_short;
            endcase
        end
    end

    // Squared thresholds are registered and follow the registers in the next cycle.
    always_ff @(posedge i_clk) begin
        r_st_sq <= THR_SQ_W'(r_short) * THR_SQ_W'(r_short);
        r_lt_sq <= THR_SQ_W'(r_long) * THR_SQ_W'(r_long);
    end

    // Source coordinates as arrays for the lanes.
    assign src_x = {r_item.src3_x, r_item.src2_x, r_item.src1_x, r_item.src0_x};
    assign src_y = {r_item.src3_y, r_item.src2_y, r_item.src1_y, r_item.src0_y};

    // One lane per source.
    for (genvar n = 0; n < NL; n++) begin : g_lane
        ipm_lane #(
            .CW(CW)
        ) u_lane (
            .i_clk   (i_clk),
            .i_tx    (r_tx),
            .i_ty    (r_ty),
            .i_sx    (src_x[n][CW-1:0]),
            .i_sy    (src_y[n][CW-1:0]),
            .i_valid (r_item.valid_mask[n]),
            .o_dist  (lane_dist[n]),
            .o_x     (lane_x[n]),
            .o_y     (lane_y[n]),
            .o_valid (lane_valid[n])
        );
    end

    ipm_merge #(
        .NL(NL),
        .CW(CW)
    ) u_merge (
        .i_clk   (i_clk),
        .i_dist  (lane_dist),
        .i_x     (lane_x),
        .i_y     (lane_y),
        .i_valid (lane_valid),
        .o_x     (pick_x),
        .o_y     (pick_y),
        .o_stat  (pick_stat)
    );

    // Window average, one divider per axis.
    ipm_div #(
        .NUM_W(SW)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sum_x),
        .i_den   (r_wc),
        .o_busy  (div_busy_x),
        .o_quo   (quo_x)
    );

    ipm_div #(
        .NUM_W(SW)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sum_y),
        .i_den   (r_wc),
        .o_busy  (div_busy_y),
        .o_quo   (quo_y)
    );

    // Shared distance unit: tracked against previous sample, or new average
    // against previous average.
    always_comb begin
        if (r_state == S_ADIST) begin
            da_x = quo_x[CW-1:0];
            da_y = quo_y[CW-1:0];
            db_x = r_pax;
            db_y = r_pay;
        end else begin
            da_x = r_tx;
            da_y = r_ty;
            db_x = r_px;
            db_y = r_py;
        end
    end

    assign dx  = (da_x > db_x) ? (da_x - db_x) : (db_x - da_x);
    assign dy  = (da_y > db_y) ? (da_y - db_y) : (db_y - da_y);
    assign sqx = (2*CW)'(dx) * (2*CW)'(dx);
    assign sqy = (2*CW)'(dy) * (2*CW)'(dy);

    always_ff @(posedge i_clk) begin
        r_dist <= {1'b0, sqx} + {1'b0, sqy};
    end

    assign d_gt_st  = CMPW'(r_dist) > CMPW'(r_st_sq);
    assign d_gt_lt  = CMPW'(r_dist) > CMPW'(r_lt_sq);
    assign wlen_eff = (r_wlen == '0) ? WLEN_W'(1) : r_wlen;

    // Idle counting and warning for the tick being finished.
    assign both      = r_is_moving && r_long_mv;
    assign idle_next = both ? '0 : ((r_idle != IDLE_MAX) ? (r_idle + 1'b1) : r_idle);
    assign warn_kept = both ? 1'b0 : r_warn;
    assign warn_rise = !warn_kept && (idle_next > r_warn_ticks);
    assign out_free  = !r_out_valid || !i_out_stall;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control strobes.
    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        out_write  = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = (i_in_data.func == FUNC_TICK) ? S_TDIST : S_RDIST;
                end
            end
            S_RDIST: n_state = S_RPICK;
            S_RPICK: n_state = S_RUPD;
            S_RUPD:  n_state = S_IDLE;
            S_TDIST: n_state = S_TACC;
            S_TACC:  n_state = S_WCHK;
            S_WCHK: begin
                if (r_wc >= wlen_eff) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (!div_busy_x && !div_busy_y) begin
                    n_state = S_ADIST;
                end
            end
            S_ADIST: n_state = S_AUPD;
            S_AUPD:  n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    out_write = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Captured request.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_in_data;
        end
    end

    // Tracking, window and inactivity state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx        <= '0;
            r_ty        <= '0;
            r_fresh     <= 1'b0;
            r_latched   <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_long_mv   <= 1'b0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_wc        <= '0;
            r_pax       <= '0;
            r_pay       <= '0;
            r_idle      <= '0;
            r_warn      <= 1'b0;
            r_is_moving <= 1'b0;
        end else begin
            case (r_state)
                // Report: latch the count while no fix is pending, take the pick.
                S_RUPD: begin
                    if (!r_fresh) begin
                        r_latched <= pick_stat.count;
                    end
                    if (pick_stat.have) begin
                        r_tx    <= pick_x;
                        r_ty    <= pick_y;
                        r_fresh <= 1'b1;
                    end
                end
                // Tick: short-term test, long jump restart and accumulation.
                S_TACC: begin
                    r_is_moving <= 1'b0;
                    if (r_fresh) begin
                        r_fresh <= 1'b0;
                        r_px    <= r_tx;
                        r_py    <= r_ty;
                        if (!r_long_mv && d_gt_lt) begin
                            r_long_mv <= 1'b1;
                            r_sum_x   <= SW'(r_tx);
                            r_sum_y   <= SW'(r_ty);
                            r_wc      <= WLEN_W'(1);
                        end else begin
                            r_is_moving <= d_gt_st;
                            r_sum_x     <= r_sum_x + SW'(r_tx);
                            r_sum_y     <= r_sum_y + SW'(r_ty);
                            r_wc        <= r_wc + 1'b1;
                        end
                    end
                end
                // Window closed: compare averages and restart the window.
                S_AUPD: begin
                    r_long_mv <= d_gt_lt;
                    r_pax     <= quo_x[CW-1:0];
                    r_pay     <= quo_y[CW-1:0];
                    r_sum_x   <= '0;
                    r_sum_y   <= '0;
                    r_wc      <= '0;
                end
                S_FIN: begin
                    if (out_write) begin
                        r_idle <= idle_next;
                        r_warn <= warn_kept || warn_rise;
                    end
                end
                default: r_idle <= r_idle;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_write) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_write) begin
            r_out.moving       <= both;
            r_out.warned       <= warn_kept || warn_rise;
            r_out.warn_start   <= warn_rise;
            r_out.source_count <= r_latched;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Accepted request keeps the input stalled in the next cycle.
    `IPM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // The divider never starts on an empty window.
    `IPM_ASSERT_IMPL(a_div_nonzero, i_clk, i_rst_n, div_start, r_wc != '0)
    // A pending fix is consumed by every tick.
    `IPM_ASSERT_NEXT(a_fix_consumed, i_clk, i_rst_n, r_state == S_TACC, !r_fresh)
    // A warning start is always reported together with the warning.
    `IPM_ASSERT_IMPL(a_start_warned, i_clk, i_rst_n, o_out_valid && o_out_data.warn_start,
        o_out_data.warned)
    // A result is written only into a free output register.
    `IPM_ASSERT_IMPL(a_out_free, i_clk, i_rst_n, out_write, !r_out_valid || !i_out_stall)

endmodule
